### src/morse_text_keyer_assert.svh
// ----------------------------------------------------------------------------
// Morse text keyer assertion macros
// Shared property forms for the keyer's port checks.
// ----------------------------------------------------------------------------
`ifndef MORSE_TEXT_KEYER_ASSERT_SVH
`define MORSE_TEXT_KEYER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/mtk_pkg.sv
// ----------------------------------------------------------------------------
// Morse text keyer package
// Segment types, echo codes and the letter pattern table.
// ----------------------------------------------------------------------------
package mtk_pkg;

	// Echo code that tells what a segment stands for.
	typedef enum logic [2:0] {
		ECHO_NONE   = 3'd0,
		ECHO_DOT    = 3'd1,
		ECHO_DASH   = 3'd2,
		ECHO_LETTER = 3'd3,
		ECHO_WORD   = 3'd4,
		ECHO_END    = 3'd5
	} echo_t;

	// One keying segment.
	typedef struct packed {
		logic       led;
		logic [2:0] dur;
		echo_t      echo;
	} seg_t;

	localparam int unsigned PAT_W = 16;
	typedef logic [PAT_W-1:0] pat_t;

	// Leading bits of the pattern: three ones are a dash, one a dot.
	localparam pat_t MASK_DASH = 16'hE000;
	localparam pat_t MASK_DOT  = 16'h8000;

	// Segment lengths in dot units.
	localparam logic [2:0] DUR_DOT    = 3'd1;
	localparam logic [2:0] DUR_DASH   = 3'd3;
	localparam logic [2:0] DUR_LETTER = 3'd3;
	localparam logic [2:0] DUR_WORD   = 3'd7;
	localparam logic [2:0] DUR_END    = 3'd0;

	// Character codes of interest.
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Element pattern of each letter, first element in the top bits.
	function automatic pat_t pattern_lookup(input logic [4:0] idx);
		pat_t p;
		case (idx)
			5'd0:    p = 16'hB800;
			5'd1:    p = 16'hEA80;
			5'd2:    p = 16'hEBA0;
			5'd3:    p = 16'hEA00;
			5'd4:    p = 16'h8000;
			5'd5:    p = 16'hAE80;
			5'd6:    p = 16'hEE80;
			5'd7:    p = 16'hAA00;
			5'd8:    p = 16'hA000;
			5'd9:    p = 16'hBBB8;
			5'd10:   p = 16'hEB80;
			5'd11:   p = 16'hBA80;
			5'd12:   p = 16'hEE00;
			5'd13:   p = 16'hE800;
			5'd14:   p = 16'hEEE0;
			5'd15:   p = 16'hBBA0;
			5'd16:   p = 16'hEEB8;
			5'd17:   p = 16'hBA00;
			5'd18:   p = 16'hA800;
			5'd19:   p = 16'hE000;
			5'd20:   p = 16'hAE00;
			5'd21:   p = 16'hAB80;
			5'd22:   p = 16'hBB80;
			5'd23:   p = 16'hEAE0;
			5'd24:   p = 16'hEBB8;
			5'd25:   p = 16'hEEA0;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

### src/mtk_shift_unit.sv
// ----------------------------------------------------------------------------
// Morse text keyer shift unit
// Classifies the leading element of a pattern and shifts it out.
// ----------------------------------------------------------------------------
module mtk_shift_unit (
	input  mtk_pkg::pat_t pat,
	output mtk_pkg::seg_t seg,
	output mtk_pkg::pat_t pat_next,
	output logic          done
);
	import mtk_pkg::*;

	// A dash takes three pattern bits, a dot or a dark unit one.
	always_comb begin
		if ((pat & MASK_DASH) == MASK_DASH) begin
			seg      = '{led: 1'b1, dur: DUR_DASH, echo: ECHO_DASH};
			pat_next = pat << 3;
		end else if ((pat & MASK_DOT) != '0) begin
			seg      = '{led: 1'b1, dur: DUR_DOT, echo: ECHO_DOT};
			pat_next = pat << 1;
		end else begin
			seg      = '{led: 1'b0, dur: DUR_DOT, echo: ECHO_NONE};
			pat_next = pat << 1;
		end
	end

	// The letter is finished once no element bits remain.
	assign done = (pat_next == '0);

endmodule

### src/morse_text_keyer.sv
// ----------------------------------------------------------------------------
// Morse text keyer
// Turns characters into Morse keying segments, one per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Ports               | Contents
//  --------+-----+---------------------+-----------------------------------------
//  input   | in  | s_tvalid/s_tready   | tdata: char_code; tlast: final_char
//  output  | out | m_tvalid/m_tready   | tdata: led_on, duration_units; tuser:
//          |     |                     | echo_symbol; tlast: last_segment
//
// An item is taken while the sequencer is idle and then causes its segments;
// a final letter causes up to 9 segments: a gap, up to 7 elements from the
// single shift unit and the closing marker.
// Reset clears the sequencer, the message state and the output register.
// A stalled output holds the current segment and pauses the sequencer; the
// input is ready only while the sequencer is idle.
// ----------------------------------------------------------------------------
module morse_text_keyer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,   // final_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] led_on, [3:1] duration_units, [7:4] zero
	output logic [2:0] m_tuser,   // [2:0] echo_symbol
	output logic       m_tlast    // last_segment
);
	import mtk_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GAP,
		ST_ELEM,
		ST_CLOSE
	} state_t;

	state_t     state_q;
	logic       letter_seen_q;
	logic       space_pending_q;
	logic       word_gap_q;
	logic       fin_q;
	pat_t       pat_q;
	logic       out_valid_q;
	seg_t       out_seg_q;
	logic       out_last_q;

	logic       is_upper;
	logic       is_lower;
	logic       is_letter;
	logic       is_space;
	logic [4:0] char_off;
	seg_t       unit_seg;
	pat_t       unit_next;
	logic       unit_done;
	logic       out_free;
	logic       out_load;

	// Character classification and table index.
	always_comb begin
		is_upper  = s_tdata inside {[CHAR_UP_A:CHAR_UP_Z]};
		is_lower  = s_tdata inside {[CHAR_LO_A:CHAR_LO_Z]};
		is_letter = is_upper || is_lower;
		is_space  = (s_tdata == CHAR_SPACE);
		char_off  = is_upper ? 5'(s_tdata - CHAR_UP_A) : 5'(s_tdata - CHAR_LO_A);
	end

	// Shared element shifter.
	mtk_shift_unit u_shift (
		.pat      (pat_q),
		.seg      (unit_seg),
		.pat_next (unit_next),
		.done     (unit_done)
	);

	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && (state_q != ST_IDLE);
	assign s_tready = (state_q == ST_IDLE);

	// Sequencer, message state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			letter_seen_q   <= 1'b0;
			space_pending_q <= 1'b0;
			word_gap_q      <= 1'b0;
			fin_q           <= 1'b0;
			pat_q           <= '0;
			out_valid_q     <= 1'b0;
			out_seg_q       <= '0;
			out_last_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						fin_q      <= s_tlast;
						word_gap_q <= space_pending_q;
						pat_q      <= pattern_lookup(char_off);
						if (is_letter) begin
							letter_seen_q   <= !s_tlast;
							space_pending_q <= 1'b0;
							state_q         <= letter_seen_q ? ST_GAP : ST_ELEM;
						end else begin
							if (s_tlast) begin
								letter_seen_q   <= 1'b0;
								space_pending_q <= 1'b0;
							end else if (is_space && letter_seen_q) begin
								space_pending_q <= 1'b1;
							end
							state_q <= s_tlast ? ST_CLOSE : ST_IDLE;
						end
					end
				end
				ST_GAP: begin
					if (out_free) begin
						out_last_q  <= 1'b0;
						out_seg_q   <= word_gap_q
							? seg_t'{led: 1'b0, dur: DUR_WORD, echo: ECHO_WORD}
							: seg_t'{led: 1'b0, dur: DUR_LETTER, echo: ECHO_LETTER};
						state_q     <= ST_ELEM;
					end
				end
				ST_ELEM: begin
					if (out_free) begin
						out_seg_q   <= unit_seg;
						out_last_q  <= unit_done && !fin_q;
						pat_q       <= unit_next;
						if (unit_done) begin
							state_q <= fin_q ? ST_CLOSE : ST_IDLE;
						end
					end
				end
				ST_CLOSE: begin
					if (out_free) begin
						out_last_q  <= 1'b1;
						out_seg_q   <= seg_t'{led: 1'b0, dur: DUR_END, echo: ECHO_END};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output port packing.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_seg_q.dur, out_seg_q.led};
	assign m_tuser  = out_seg_q.echo;
	assign m_tlast  = out_last_q;

endmodule

### src/mtk_checker.sv
// ----------------------------------------------------------------------------
// Morse text keyer checker
// Port-level checks on the keyer, bound to the top level.
// ----------------------------------------------------------------------------
`include "morse_text_keyer_assert.svh"

module mtk_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [2:0] m_tuser,
	input logic       m_tlast
);
	import mtk_pkg::*;

	// A stalled segment stays in place.
	`MTK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output item changed while stalled")

	// The closing marker is dark, zero length and the last segment.
	`MTK_ASSERT_NOW(a_end_marker, m_tvalid && (m_tuser == ECHO_END), m_tlast && (m_tdata == 8'h00), "malformed closing marker")

	// A lit segment is a dot of one unit or a dash of three.
	`MTK_ASSERT_NOW(a_lit_element, m_tvalid && m_tdata[0], ((m_tdata[3:1] == DUR_DOT) && (m_tuser == ECHO_DOT)) || ((m_tdata[3:1] == DUR_DASH) && (m_tuser == ECHO_DASH)), "lit segment with bad length or echo")

	// While segments of an item are still to come, no new item is taken.
	`MTK_ASSERT_NOW(a_busy_mid_item, m_tvalid && !m_tlast, !s_tready, "input ready in the middle of an item")

	// Pad bits of the output data are zero.
	`MTK_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:4] == 4'b0000, "output pad bits not zero")

endmodule

bind morse_text_keyer mtk_checker u_mtk_checker (.*);
